// ----- sv/mxm_pkg.sv -----
// Package: widths, register indexes and reset values for the quad X motor mixer.
package mxm_pkg;

  // Field widths
  localparam int ThrW    = 15;
  localparam int DriveW  = 13;
  localparam int TimeW   = 32;
  localparam int PeriodW = 10;
  localparam int CountW  = 16;
  localparam int MixW    = 18;
  localparam int CfgIdxW = 3;
  localparam int CfgDatW = 15;

  typedef logic [ThrW-1:0]           thr_t;
  typedef logic signed [DriveW-1:0]  drive_t;
  typedef logic [TimeW-1:0]          ms_t;
  typedef logic [PeriodW-1:0]        period_t;
  typedef logic [CountW-1:0]         count_t;
  typedef logic signed [MixW-1:0]    mix_t;
  typedef logic [CfgIdxW-1:0]        cfg_idx_t;
  typedef logic [CfgDatW-1:0]        cfg_dat_t;

  // Register indexes
  localparam cfg_idx_t RegThrMin   = 3'd0;
  localparam cfg_idx_t RegThrIdle  = 3'd1;
  localparam cfg_idx_t RegThrMax   = 3'd2;
  localparam cfg_idx_t RegThrWork  = 3'd3;
  localparam cfg_idx_t RegSpinPer  = 3'd4;

  // Register reset values
  localparam thr_t    RstThrMin  = 15'd1000;
  localparam thr_t    RstThrIdle = 15'd1100;
  localparam thr_t    RstThrMax  = 15'd2000;
  localparam thr_t    RstThrWork = 15'd1150;
  localparam period_t RstSpinPer = 10'd5;

endpackage

// ----- sv/mxm_in_if.sv -----
// Interface: control tick input channel.
interface mxm_in_if import mxm_pkg::*;;
  logic   valid;
  logic   ready;
  logic   unlocked;
  thr_t   throttle;
  drive_t roll_drive;
  drive_t pitch_drive;
  drive_t yaw_drive;
  logic   auto_relock_pending;
  logic   yaw_returned;
  ms_t    now_ms;

  modport source (output valid, unlocked, throttle, roll_drive, pitch_drive, yaw_drive,
                  auto_relock_pending, yaw_returned, now_ms, input ready);
  modport sink (input valid, unlocked, throttle, roll_drive, pitch_drive, yaw_drive,
                auto_relock_pending, yaw_returned, now_ms, output ready);
endinterface

// ----- sv/mxm_out_if.sv -----
// Interface: motor command result channel.
interface mxm_out_if import mxm_pkg::*;;
  logic valid;
  logic ready;
  thr_t motor_front_a;
  thr_t motor_front_b;
  thr_t motor_rear_a;
  thr_t motor_rear_b;
  logic clear_integrators;
  logic spinup_busy;

  modport source (output valid, motor_front_a, motor_front_b, motor_rear_a, motor_rear_b,
                  clear_integrators, spinup_busy, input ready);
  modport sink (input valid, motor_front_a, motor_front_b, motor_rear_a, motor_rear_b,
                clear_integrators, spinup_busy, output ready);
endinterface

// ----- sv/mxm_cfg_if.sv -----
// Interface: configuration register write channel.
interface mxm_cfg_if import mxm_pkg::*;;
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  cfg_dat_t data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/quad_x_motor_mixer_with_spinup.sv -----
// Top level: quad X motor mixer with spin-up sequence and unlocked clamp.
//
//   channel  direction  handshake          payload
//   in_ch    in         valid/ready        lock, throttle, drives, flags, now_ms
//   out_ch   out        valid/ready        four motor commands, clear, busy
//   cfg_ch   in         valid/ready (=1)   register index, write data
//
// One tick per cycle while out_ch is not stalled: each transfer is mixed and
// clamped combinationally and lands in the output register in the cycle after.
// The output register is the only stage; a new tick is taken whenever it is
// empty or being drained in the same cycle.
// rst_n is synchronous: clears the output valid, the spin-up state and loads
// the register reset values. Configuration writes are always taken.
module quad_x_motor_mixer_with_spinup import mxm_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  mxm_in_if.sink    in_ch,
  mxm_out_if.source out_ch,
  mxm_cfg_if.sink   cfg_ch
);

  // Clamp a wide mixer value to idle..max, testing against idle first
  function automatic thr_t clamp_unl(mix_t v, thr_t lo, thr_t hi);
    mix_t lo_w;
    mix_t hi_w;
    lo_w = mix_t'({3'b000, lo});
    hi_w = mix_t'({3'b000, hi});
    if (v < lo_w)      return lo;
    else if (v > hi_w) return hi;
    else               return v[ThrW-1:0];
  endfunction

  // Configuration registers
  thr_t    thr_min_r, thr_idle_r, thr_max_r, thr_work_r;
  period_t spin_per_r;

  // Spin-up state
  logic    armed_r, armed_nxt;
  count_t  count_r, count_nxt;
  ms_t     last_r, last_nxt;

  // Output register
  logic    out_valid_r;
  thr_t    mfa_r, mfb_r, mra_r, mrb_r;
  thr_t    mfa_nxt, mfb_nxt, mra_nxt, mrb_nxt;
  logic    clr_r, clr_nxt;
  logic    busy_r, busy_nxt;

  logic    in_fire;
  ms_t     elapsed;
  logic    step_due;
  count_t  count_step;
  mix_t    spin_val;
  logic    spin_end;
  mix_t    thr_w, roll_w, pitch_w, yaw_w;
  mix_t    m0, m1, m2, m3;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;

  // Spin-up step and end test
  assign elapsed    = in_ch.now_ms - last_r;
  assign step_due   = elapsed > {{(TimeW-PeriodW){1'b0}}, spin_per_r};
  assign count_step = step_due ? count_r + count_t'(1) : count_r;
  assign spin_val   = mix_t'({3'b000, thr_min_r}) + mix_t'({2'b00, count_step});
  assign spin_end   = mix_t'({2'b00, count_step}) >=
                      (mix_t'({3'b000, thr_idle_r}) - mix_t'({3'b000, thr_min_r}));

  // Widen the mixer operands
  assign thr_w   = mix_t'({3'b000, in_ch.throttle});
  assign roll_w  = mix_t'(in_ch.roll_drive);
  assign pitch_w = mix_t'(in_ch.pitch_drive);
  assign yaw_w   = mix_t'(in_ch.yaw_drive);

  // Select the motor values for this tick
  always_comb begin
    armed_nxt = armed_r;
    count_nxt = count_r;
    last_nxt  = last_r;
    clr_nxt   = 1'b0;
    busy_nxt  = 1'b0;
    m0 = thr_w;
    m1 = thr_w;
    m2 = thr_w;
    m3 = thr_w;
    if (armed_r) begin
      busy_nxt = 1'b1;
      m0 = spin_val;
      m1 = spin_val;
      m2 = spin_val;
      m3 = spin_val;
      if (spin_end) begin
        armed_nxt = 1'b0;
        count_nxt = '0;
        last_nxt  = '0;
      end else begin
        count_nxt = count_step;
        if (step_due) last_nxt = in_ch.now_ms;
      end
    end else if (in_ch.throttle >= thr_work_r) begin
      m0 = thr_w - roll_w + pitch_w - yaw_w;
      m1 = thr_w + roll_w - pitch_w - yaw_w;
      m2 = thr_w + roll_w + pitch_w + yaw_w;
      m3 = thr_w - roll_w - pitch_w + yaw_w;
    end else begin
      clr_nxt = 1'b1;
    end
    if (in_ch.auto_relock_pending && in_ch.yaw_returned) clr_nxt = 1'b1;
    mfa_nxt = clamp_unl(m0, thr_idle_r, thr_max_r);
    mfb_nxt = clamp_unl(m1, thr_idle_r, thr_max_r);
    mra_nxt = clamp_unl(m2, thr_idle_r, thr_max_r);
    mrb_nxt = clamp_unl(m3, thr_idle_r, thr_max_r);
    // Locked: hold motors at minimum and rearm the spin-up
    if (!in_ch.unlocked) begin
      armed_nxt = 1'b1;
      count_nxt = '0;
      last_nxt  = '0;
      clr_nxt   = 1'b1;
      busy_nxt  = 1'b0;
      mfa_nxt   = thr_min_r;
      mfb_nxt   = thr_min_r;
      mra_nxt   = thr_min_r;
      mrb_nxt   = thr_min_r;
    end
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_min_r  <= RstThrMin;
      thr_idle_r <= RstThrIdle;
      thr_max_r  <= RstThrMax;
      thr_work_r <= RstThrWork;
      spin_per_r <= RstSpinPer;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        RegThrMin:  thr_min_r  <= cfg_ch.data;
        RegThrIdle: thr_idle_r <= cfg_ch.data;
        RegThrMax:  thr_max_r  <= cfg_ch.data;
        RegThrWork: thr_work_r <= cfg_ch.data;
        RegSpinPer: spin_per_r <= cfg_ch.data[PeriodW-1:0];
        default: ;
      endcase
    end
  end

  // Advance spin-up state on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0;
      count_r <= '0;
      last_r  <= '0;
    end else if (in_fire) begin
      armed_r <= armed_nxt;
      count_r <= count_nxt;
      last_r  <= last_nxt;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mfa_r  <= mfa_nxt;
      mfb_r  <= mfb_nxt;
      mra_r  <= mra_nxt;
      mrb_r  <= mrb_nxt;
      clr_r  <= clr_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.motor_front_a     = mfa_r;
  assign out_ch.motor_front_b     = mfb_r;
  assign out_ch.motor_rear_a      = mra_r;
  assign out_ch.motor_rear_b      = mrb_r;
  assign out_ch.clear_integrators = clr_r;
  assign out_ch.spinup_busy       = busy_r;

endmodule

// ----- sv/mxm_checker.sv -----
// Checker: port-level assertions for the quad X motor mixer, bound to the top level.
module mxm_checker import mxm_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_unlocked,
  input logic in_relock,
  input logic in_yaw_ret,
  input logic out_valid,
  input logic out_ready,
  input thr_t out_mfa,
  input thr_t out_mfb,
  input thr_t out_mra,
  input thr_t out_mrb,
  input logic out_clr,
  input logic out_busy
);

  logic in_xfer;
  assign in_xfer = in_valid && in_ready;

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mfa) && $stable(out_clr))
    else $error("stalled result changed");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Locked tick: equal motors, clear raised, no spin-up
  a_locked: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && !in_unlocked |=> out_valid && out_clr && !out_busy &&
      out_mfa == out_mfb && out_mfa == out_mra && out_mfa == out_mrb)
    else $error("locked tick result wrong");

  // Relock with yaw centered always clears integrators
  a_relock_clr: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_relock && in_yaw_ret |=> out_valid && out_clr)
    else $error("integrator clear missing on relock");

endmodule

bind quad_x_motor_mixer_with_spinup mxm_checker u_mxm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_unlocked(in_ch.unlocked),
  .in_relock  (in_ch.auto_relock_pending),
  .in_yaw_ret (in_ch.yaw_returned),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_mfa    (out_ch.motor_front_a),
  .out_mfb    (out_ch.motor_front_b),
  .out_mra    (out_ch.motor_rear_a),
  .out_mrb    (out_ch.motor_rear_b),
  .out_clr    (out_ch.clear_integrators),
  .out_busy   (out_ch.spinup_busy)
);
